// ----- design/vle_pkg.sv -----
// Shared types and constants for the variable-length integer decoder.
`timescale 1ns / 1ps
`default_nettype none

package vle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned GroupW = 7;
  localparam int unsigned ValueW = 64;
  localparam int unsigned LenW   = 32;
  localparam int unsigned ShiftW = 7;

  localparam logic [ByteW-1:0] GroupMask = 8'h7f;

  localparam logic [1:0] KIND_INT     = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ValueW-1:0] value;
    logic              last;
    logic              overflow;
  } result_t;

endpackage

`default_nettype wire

// ----- design/vle_core.sv -----
// Decode state and per-byte update logic for the variable-length integer decoder.
`timescale 1ns / 1ps
`default_nettype none

module vle_core
  import vle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [ByteW-1:0] byte_in,
  input  wire logic             mode,
  output logic                  emit,
  output result_t               res
);

  logic [ValueW-1:0] accumulator;
  logic [ValueW-1:0] accumulator_next;
  logic [ShiftW-1:0] shift_position;
  logic [ShiftW-1:0] shift_position_next;
  logic              in_payload;
  logic              in_payload_next;
  logic [LenW-1:0]   bytes_remaining;
  logic [LenW-1:0]   bytes_remaining_next;
  logic              dropped_bits;
  logic              dropped_bits_next;

  logic [GroupW-1:0]        group;
  logic [ValueW+GroupW-1:0] shifted;
  logic [ValueW-1:0]        acc_sum;
  logic                     drop_sum;
  logic                     fin;

  assign group   = byte_in[GroupW-1:0] & GroupMask[GroupW-1:0];
  assign shifted = {{ValueW{1'b0}}, group} << shift_position[5:0];
  assign fin     = (bytes_remaining <= LenW'(1));

  always_comb begin
    accumulator_next     = accumulator;
    shift_position_next  = shift_position;
    in_payload_next      = in_payload;
    bytes_remaining_next = bytes_remaining;
    dropped_bits_next    = dropped_bits;
    acc_sum              = accumulator;
    drop_sum             = dropped_bits;
    emit                 = 1'b0;
    res.kind             = KIND_INT;
    res.value            = '0;
    res.last             = 1'b0;
    res.overflow         = 1'b0;

    if (in_payload) begin
      emit                 = 1'b1;
      res.kind             = KIND_PAYLOAD;
      res.value            = {{(ValueW-ByteW){1'b0}}, byte_in};
      res.last             = fin;
      bytes_remaining_next = fin ? '0 : bytes_remaining - LenW'(1);
      in_payload_next      = !fin;
    end else begin
      if (shift_position < ShiftW'(ValueW)) begin
        acc_sum             = accumulator | shifted[ValueW-1:0];
        drop_sum            = dropped_bits | (|shifted[ValueW+GroupW-1:ValueW]);
        shift_position_next = shift_position + ShiftW'(GroupW);
      end else begin
        drop_sum = dropped_bits | (|group);
      end
      accumulator_next  = acc_sum;
      dropped_bits_next = drop_sum;

      if (!byte_in[ByteW-1]) begin
        emit = 1'b1;
        if (!mode) begin
          res.kind     = KIND_INT;
          res.value    = acc_sum;
          res.last     = 1'b1;
          res.overflow = drop_sum;
        end else begin
          res.kind     = KIND_HEADER;
          res.value    = {{(ValueW-LenW){1'b0}}, acc_sum[LenW-1:0]};
          res.last     = (acc_sum[LenW-1:0] == '0);
          res.overflow = drop_sum | (|acc_sum[ValueW-1:LenW]);
          if (acc_sum[LenW-1:0] != '0) begin
            in_payload_next      = 1'b1;
            bytes_remaining_next = acc_sum[LenW-1:0];
          end
        end
        accumulator_next    = '0;
        shift_position_next = '0;
        dropped_bits_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      shift_position  <= '0;
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
      dropped_bits    <= 1'b0;
    end else if (fire) begin
      accumulator     <= accumulator_next;
      shift_position  <= shift_position_next;
      in_payload      <= in_payload_next;
      bytes_remaining <= bytes_remaining_next;
      dropped_bits    <= dropped_bits_next;
    end
  end

  // A payload in progress always has at least one byte left to pass.
  assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (bytes_remaining != '0))
    else $error("payload active with zero bytes remaining");

  // The shift stops one group past the top of the accumulator.
  assert property (@(posedge clk) disable iff (rst)
    shift_position <= ShiftW'(ValueW + GroupW - 1))
    else $error("shift position ran past its limit");

  // Payload bytes never report overflow.
  assert property (@(posedge clk) disable iff (rst)
    (emit && res.kind == KIND_PAYLOAD) |-> !res.overflow)
    else $error("payload result flagged overflow");

  // Passing the final payload byte returns the decoder to reading a length.
  assert property (@(posedge clk) disable iff (rst)
    (fire && in_payload && bytes_remaining == LenW'(1)) |=> !in_payload)
    else $error("payload did not end after its final byte");

endmodule

`default_nettype wire

// ----- design/vle_length_prefixed_decoder_unit.sv -----
// Top level of the variable-length integer and length-prefixed array decoder.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a stream of LEB128-style wire bytes, one byte per transaction. In integer
// mode each finished varint is delivered as one result; in array mode it is delivered
// as a length header and the following bytes pass through as payload results, the
// final one marked last. The decoder sustains one byte per clock cycle while the output
// is not stalled: every byte needs only a mask, a shift and an OR on the accumulator,
// done between the input register and the result register. Continuation bytes produce
// no result. The array_mode register is written through its own valid/ready port,
// which is always ready, and is sampled when a varint finishes.
module vle_length_prefixed_decoder_unit
  import vle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              array_mode,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ByteW-1:0]  wire_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic [ValueW-1:0]      value,
  output logic                   last,
  output logic                   overflow
);

  logic             mode;
  logic             in_full;
  logic [ByteW-1:0] in_byte;
  logic             fire;
  logic             emit;
  result_t          res;
  result_t          out_res;

  assign cfg_ready = 1'b1;
  assign fire      = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= array_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_byte <= wire_byte;
    end
  end

  vle_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (in_byte),
    .mode    (mode),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire && emit) begin
      out_res <= res;
    end
  end

  assign kind     = out_res.kind;
  assign value    = out_res.value;
  assign last     = out_res.last;
  assign overflow = out_res.overflow;

endmodule

`default_nettype wire
